/* hdl/pgdd_pkg.sv */
// ----------------------------------------------------------------------------
// pgdd_pkg: shared types and constants for the diffusion-decay grid
// command/result payloads, opcodes, status codes, controller command bundle
// ----------------------------------------------------------------------------
package pgdd_pkg;

  localparam int X_CELLS_DEF = 16;
  localparam int Y_CELLS_DEF = 16;
  localparam int Z_CELLS_DEF = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;

  localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         x_index;
    logic [3:0]         y_index;
    logic [3:0]         z_index;
    logic signed [31:0] amount;
    logic [7:0]         step_count;
  } request_t;

  typedef struct packed {
    logic [30:0] cell_value;
    logic [1:0]  status;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request and sizes
    logic cell_rd;    // read addressed cell
    logic cell_wr;    // write / add back and present result
    logic sweep_start;// reset sweep counters
    logic sweep_en;   // advance compute sweep
    logic copy_start;
    logic copy_en;    // advance copy sweep
    logic clr_en;     // clearing pass
    logic run_done;   // present run result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_err;
    logic sweep_last;
    logic copy_last;
    logic clr_last;
    logic pipe_empty;
  } dp_stat_t;

endpackage

/* hdl/periodic_grid_diffusion_decay.sv */
// ----------------------------------------------------------------------------
// periodic_grid_diffusion_decay: periodic 3D diffusion-decay grid
// seven-point explicit stencil over a wrapped grid with cell access commands
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows as a one-cycle pulse on done, which the receiver cannot stall.
// Write, add and read pass through a read state, then a write state. Each
// run sub-step sweeps the cells in use: the old grid has one read port, so each
// cell needs seven reads (itself and six wrapped neighbours), followed by a
// copy-back pass of one cell a cycle. After reset the grid is cleared one
// cell a cycle (all 4096 cells at the default size) while busy stays high;
// register writes are accepted during that time.
module periodic_grid_diffusion_decay #(
  parameter int X_CELLS = pgdd_pkg::X_CELLS_DEF,
  parameter int Y_CELLS = pgdd_pkg::Y_CELLS_DEF,
  parameter int Z_CELLS = pgdd_pkg::Z_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pgdd_pkg::request_t request,
  output logic               done,
  output pgdd_pkg::result_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pgdd_pkg::*;

  localparam logic [2:0] R_XS = 3'd0, R_YS = 3'd1, R_ZS = 3'd2, R_DEC = 3'd3, R_DIF = 3'd4;

  logic [4:0]  x_size, y_size, z_size;
  logic [15:0] decay_rate;
  logic [13:0] diff_rate;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  // register file, byte addressed, word aligned
  always_ff @(posedge clk) begin
    if (rst) begin
      x_size <= 5'd1; y_size <= 5'd1; z_size <= 5'd1;
      decay_rate <= '0; diff_rate <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        R_XS:  x_size     <= pwdata[4:0];
        R_YS:  y_size     <= pwdata[4:0];
        R_ZS:  z_size     <= pwdata[4:0];
        R_DEC: decay_rate <= pwdata[15:0];
        R_DIF: diff_rate  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      R_XS:  prdata = {27'b0, x_size};
      R_YS:  prdata = {27'b0, y_size};
      R_ZS:  prdata = {27'b0, z_size};
      R_DEC: prdata = {16'b0, decay_rate};
      R_DIF: prdata = {18'b0, diff_rate};
      default: prdata = '0;
    endcase
  end

  pgdd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(request.op),
    .step_count(request.step_count), .stat(stat), .cmd(cmd), .busy(busy)
  );

  pgdd_datapath #(.X_CELLS(X_CELLS), .Y_CELLS(Y_CELLS), .Z_CELLS(Z_CELLS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(request),
    .x_size(x_size), .y_size(y_size), .z_size(z_size),
    .decay_rate(decay_rate), .diff_rate(diff_rate),
    .stat(stat), .result_valid(done), .result(result)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_no_done_idle_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done) else $error("result too early");
  a_done_not_while_free: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("stray result");
endmodule

/* hdl/pgdd_ctrl.sv */
// ----------------------------------------------------------------------------
// pgdd_ctrl: sequencing controller
// steps through cell access, sub-step sweeps, copy-back and reset clearing
// ----------------------------------------------------------------------------
module pgdd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  logic [7:0]        step_count,
  input  pgdd_pkg::dp_stat_t stat,
  output pgdd_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import pgdd_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CELL_RD, S_CELL_WR, S_SWEEP, S_DRAIN, S_COPY, S_DONE
  } state_t;

  state_t     state;
  logic [7:0] steps_left;

  always_comb begin
    cmd = '0;
    cmd.capture     = (state == S_IDLE) && start;
    cmd.cell_rd     = state == S_CELL_RD;
    cmd.cell_wr     = state == S_CELL_WR;
    cmd.sweep_start = ((state == S_IDLE) && start && op == OP_RUN) || (state == S_COPY && stat.copy_last);
    cmd.sweep_en    = state == S_SWEEP;
    cmd.copy_start  = state == S_DRAIN && stat.pipe_empty;
    cmd.copy_en     = state == S_COPY;
    cmd.clr_en      = state == S_CLEAR;
    cmd.run_done    = state == S_DONE;
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      steps_left <= '0;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clr_last) state <= S_IDLE;
        S_IDLE: if (start) begin
          if (op == OP_RUN) begin
            steps_left <= step_count;
            state      <= (step_count == '0) ? S_DONE : S_SWEEP;
          end else begin
            state <= S_CELL_RD;
          end
        end
        S_CELL_RD: state <= S_CELL_WR;
        S_CELL_WR: state <= S_IDLE;
        S_SWEEP: if (stat.sweep_last) state <= S_DRAIN;
        S_DRAIN: if (stat.pipe_empty) state <= S_COPY;
        S_COPY: if (stat.copy_last) begin
          steps_left <= steps_left - 8'd1;
          state      <= (steps_left == 8'd1) ? S_DONE : S_SWEEP;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_run_has_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (steps_left != '0)) else $error("sweep with no steps left");
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (steps_left == '0)) else $error("steps left while idle");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL_RD) |=> (state == S_CELL_WR)) else $error("cell access broken");
endmodule

/* hdl/pgdd_datapath.sv */
// ----------------------------------------------------------------------------
// pgdd_datapath: grid memories and stencil arithmetic
// one neighbour read per cycle from the old grid, accumulate, update, copy back
// ----------------------------------------------------------------------------
module pgdd_datapath #(
  parameter int X_CELLS = pgdd_pkg::X_CELLS_DEF,
  parameter int Y_CELLS = pgdd_pkg::Y_CELLS_DEF,
  parameter int Z_CELLS = pgdd_pkg::Z_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pgdd_pkg::dp_cmd_t  cmd,
  input  pgdd_pkg::request_t req,
  input  logic [4:0]         x_size,
  input  logic [4:0]         y_size,
  input  logic [4:0]         z_size,
  input  logic [15:0]        decay_rate,
  input  logic [13:0]        diff_rate,
  output pgdd_pkg::dp_stat_t stat,
  output logic               result_valid,
  output pgdd_pkg::result_t  result
);
  import pgdd_pkg::*;

  localparam int XW = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
  localparam int YW = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;
  localparam int ZW = (Z_CELLS > 1) ? $clog2(Z_CELLS) : 1;
  localparam int AW = XW + YW + ZW;
  localparam int CELLS = X_CELLS * Y_CELLS * Z_CELLS;
  localparam int SW = 9;  // sizes up to 511

  logic [30:0] conc_mem [CELLS];
  logic [30:0] next_mem [CELLS];

  // effective sizes
  function automatic logic [SW-1:0] eff(input logic [4:0] r, input int cap);
    logic [SW-1:0] c;
    c = SW'(cap);
    if (r == '0) return SW'(1);
    if ({4'b0, r} > c) return c;
    return {4'b0, r};
  endfunction

  logic [SW-1:0] xs, ys, zs;
  request_t      rq;

  function automatic logic [AW-1:0] addr(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                         input logic [ZW-1:0] z);
    return AW'((AW'(x) * AW'(Y_CELLS) + AW'(y)) * AW'(Z_CELLS) + AW'(z));
  endfunction

  // -------- single-cell access
  logic        range_bad;
  logic [30:0] cell_q;
  assign range_bad = ({5'b0, rq.x_index} >= xs) || ({5'b0, rq.y_index} >= ys) ||
                     ({5'b0, rq.z_index} >= zs);
  assign stat.range_err = range_bad;

  logic signed [33:0] cell_sum;
  always_comb begin
    if (rq.op == OP_WRITE) cell_sum = 34'(rq.amount);
    else cell_sum = $signed({3'b0, cell_q}) + 34'(rq.amount);
  end

  // -------- sweep: counters over cell (x,y,z) and phase 0..6
  logic [XW-1:0] sx; logic [YW-1:0] sy; logic [ZW-1:0] sz;
  logic [2:0]    ph;
  logic          cell_last;
  assign cell_last = (SW'(sx) == xs - 1) && (SW'(sy) == ys - 1) && (SW'(sz) == zs - 1);
  assign stat.sweep_last = cmd.sweep_en && ph == 3'd6 && cell_last;

  function automatic logic [XW-1:0] dn_x(input logic [XW-1:0] i);
    return (i == '0) ? XW'(xs - 1) : i - 1'b1;
  endfunction
  function automatic logic [XW-1:0] up_x(input logic [XW-1:0] i);
    return (SW'(i) + 1 >= xs) ? '0 : i + 1'b1;
  endfunction
  function automatic logic [YW-1:0] dn_y(input logic [YW-1:0] i);
    return (i == '0) ? YW'(ys - 1) : i - 1'b1;
  endfunction
  function automatic logic [YW-1:0] up_y(input logic [YW-1:0] i);
    return (SW'(i) + 1 >= ys) ? '0 : i + 1'b1;
  endfunction
  function automatic logic [ZW-1:0] dn_z(input logic [ZW-1:0] i);
    return (i == '0) ? ZW'(zs - 1) : i - 1'b1;
  endfunction
  function automatic logic [ZW-1:0] up_z(input logic [ZW-1:0] i);
    return (SW'(i) + 1 >= zs) ? '0 : i + 1'b1;
  endfunction

  logic [AW-1:0] rd_addr;
  always_comb begin
    unique case (ph)
      3'd1: rd_addr = addr(dn_x(sx), sy, sz);
      3'd2: rd_addr = addr(up_x(sx), sy, sz);
      3'd3: rd_addr = addr(sx, dn_y(sy), sz);
      3'd4: rd_addr = addr(sx, up_y(sy), sz);
      3'd5: rd_addr = addr(sx, sy, dn_z(sz));
      3'd6: rd_addr = addr(sx, sy, up_z(sz));
      default: rd_addr = addr(sx, sy, sz);
    endcase
  end

  // clear counter (the copy sweep uses cx, cy, cz)
  logic [AW:0]   cc;
  logic [AW-1:0] cc_a;
  assign cc_a = cc[AW-1:0];
  assign stat.clr_last  = cc == (AW+1)'(CELLS - 1);
  logic [XW-1:0] cx; logic [YW-1:0] cy; logic [ZW-1:0] cz;
  assign stat.copy_last = cmd.copy_en && (SW'(cx) == xs - 1) && (SW'(cy) == ys - 1) &&
                          (SW'(cz) == zs - 1);

  // pipeline: s1 read data valid, accumulate
  logic          v1, last1;
  logic [2:0]    ph1;
  logic [AW-1:0] a1;
  logic [30:0]   rd_q;
  logic [30:0]   c_cur;
  logic signed [34:0] s_acc;
  // stage 2: products
  logic          v2;
  logic [AW-1:0] a2;
  logic signed [48:0] p_dec_n;   // c*65536 - decay*c, as c*(65536-decay)
  logic signed [51:0] p_dif;
  // stage 3: sum and saturate
  logic          v3;
  logic [AW-1:0] a3;
  logic signed [52:0] acc3;
  logic          clamp_any;

  assign stat.pipe_empty = !v1 && !v2 && !v3;

  logic signed [35:0] s_new;
  assign s_new = s_acc + $signed({4'b0, rd_q}) - $signed({4'b0, c_cur});

  logic [52:0] rnd;
  assign rnd = 53'(acc3) + 53'h8000;

  logic [AW-1:0] mem_rd_a;
  assign mem_rd_a = cmd.sweep_en ? rd_addr :
                    cmd.copy_en ? addr(cx, cy, cz) :
                    addr(XW'(rq.x_index), YW'(rq.y_index), ZW'(rq.z_index));

  // copy pipeline: registered address and valid
  logic          cv;
  logic [AW-1:0] ca;

  // the last copy-back write lands in the first cycle of the next sweep (if any),
  // so a read of that same cell takes the value being written
  logic [30:0] conc_rd, next_rd;
  always_ff @(posedge clk) begin
    conc_rd <= (cv && ca == mem_rd_a) ? next_rd : conc_mem[mem_rd_a];
    next_rd <= next_mem[addr(cx, cy, cz)];
  end
  assign rd_q   = conc_rd;
  assign cell_q = conc_rd;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq <= req;
      xs <= eff(x_size, X_CELLS);
      ys <= eff(y_size, Y_CELLS);
      zs <= eff(z_size, Z_CELLS);
    end
    // memory writes
    if (cmd.clr_en) conc_mem[cc_a] <= '0;
    else if (cmd.cell_wr && !range_bad && rq.op != OP_READ) begin
      conc_mem[addr(XW'(rq.x_index), YW'(rq.y_index), ZW'(rq.z_index))] <=
        (cell_sum < 0) ? 31'd0 : (cell_sum > $signed({3'b0, VAL_MAX})) ? VAL_MAX :
        cell_sum[30:0];
    end else if (cv) conc_mem[ca] <= next_rd;
    if (v3) begin
      if (acc3 < 0) next_mem[a3] <= '0;
      else if (rnd[52:16] > 37'(VAL_MAX)) next_mem[a3] <= VAL_MAX;
      else next_mem[a3] <= rnd[46:16];
    end
    // stage 1 accumulate
    if (v1) begin
      if (ph1 == 3'd0) begin c_cur <= rd_q; s_acc <= '0; end
      else s_acc <= 35'(s_new);
    end
    a2 <= a1;
    p_dec_n <= $signed({18'b0, c_cur}) * $signed({1'b0, 17'(18'h10000 - 18'(decay_rate))});
    p_dif   <= 52'(s_new) * $signed({1'b0, diff_rate});
    a3   <= a2;
    acc3 <= 53'(p_dec_n) + 53'(p_dif);
    ca <= addr(cx, cy, cz);
    cv <= cmd.copy_en;
  end

  // p_dif samples s_new when last1; use registered inputs only then (v2 gates use)

  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= '0; sx <= '0; sy <= '0; sz <= '0; ph <= '0;
      cx <= '0; cy <= '0; cz <= '0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; clamp_any <= 1'b0; result_valid <= 1'b0;
    end else begin
      if (cmd.clr_en) cc <= cc + 1'b1;
      v1    <= cmd.sweep_en;
      ph1   <= ph;
      last1 <= ph == 3'd6;
      a1    <= addr(sx, sy, sz);
      v2    <= v1 && last1;
      v3    <= v2;
      if (cmd.sweep_start) begin
        sx <= '0; sy <= '0; sz <= '0; ph <= '0;
      end else if (cmd.sweep_en) begin
        if (ph != 3'd6) ph <= ph + 1'b1;
        else begin
          ph <= '0;
          if (SW'(sz) + 1 < zs) sz <= sz + 1'b1;
          else begin
            sz <= '0;
            if (SW'(sy) + 1 < ys) sy <= sy + 1'b1;
            else begin sy <= '0; sx <= sx + 1'b1; end
          end
        end
      end
      if (cmd.copy_start) begin
        cx <= '0; cy <= '0; cz <= '0;
      end else if (cmd.copy_en) begin
        if (SW'(cz) + 1 < zs) cz <= cz + 1'b1;
        else begin
          cz <= '0;
          if (SW'(cy) + 1 < ys) cy <= cy + 1'b1;
          else begin cy <= '0; cx <= cx + 1'b1; end
        end
      end
      if (cmd.capture) clamp_any <= 1'b0;
      else if (v3 && (acc3 < 0 || rnd[52:16] > 37'(VAL_MAX))) clamp_any <= 1'b1;
      result_valid <= cmd.cell_wr || cmd.run_done;
      if (cmd.run_done) begin
        result.cell_value <= '0;
        result.status     <= clamp_any ? ST_CLAMP : ST_OK;
      end else if (cmd.cell_wr) begin
        if (range_bad) begin
          result.cell_value <= '0;
          result.status     <= ST_RANGE;
        end else if (rq.op == OP_READ) begin
          result.cell_value <= cell_q;
          result.status     <= ST_OK;
        end else begin
          result.cell_value <= (cell_sum < 0) ? 31'd0 :
            (cell_sum > $signed({3'b0, VAL_MAX})) ? VAL_MAX : cell_sum[30:0];
          result.status <= (cell_sum < 0 || cell_sum > $signed({3'b0, VAL_MAX})) ?
                           ST_CLAMP : ST_OK;
        end
      end
    end
  end

  a_no_copy_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_en |-> !v3) else $error("copy while update pending");
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep_en && cmd.copy_en)) else $error("sweep and copy overlap");
  a_result_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result held two cycles");
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the periodic diffusion-decay grid
// drives cell writes, adds, reads and runs through the command port, sets the
// grid size and rate factors over the register port, and checks each result
// against an in-bench model of the wrapped seven-point stencil
// ----------------------------------------------------------------------------
module tb_top;
  import pgdd_pkg::*;

  localparam int GRID      = 16;
  localparam int CELLS     = GRID * GRID * GRID;
  localparam int IDLE_LIMIT = 250000;

  // register byte addresses
  localparam logic [4:0] REG_X_SIZE = 5'd0;
  localparam logic [4:0] REG_Y_SIZE = 5'd4;
  localparam logic [4:0] REG_Z_SIZE = 5'd8;
  localparam logic [4:0] REG_DECAY  = 5'd12;
  localparam logic [4:0] REG_DIFF   = 5'd16;
  localparam logic [4:0] REG_UNUSED = 5'd20;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;
  logic     psel;
  logic     penable;
  logic     pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  periodic_grid_diffusion_decay u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // clock: 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // grid model: own copy of the cells and of the registers
  // ---------------------------------------------------------------------------
  logic [30:0] grid_cells [CELLS];
  logic [30:0] grid_next  [CELLS];
  logic [4:0]  x_size_reg, y_size_reg, z_size_reg;
  logic [15:0] decay_reg;
  logic [13:0] diff_reg;

  result_t expected_results [$];
  int      failures;
  int      idle_cycles;
  bit      allow_idle;

  function automatic int eff_size(logic [4:0] r);
    if (r == 0) return 1;
    if (r > GRID) return GRID;
    return int'(r);
  endfunction

  function automatic int cell_at(int x, int y, int z);
    return (x * GRID + y) * GRID + z;
  endfunction

  // one explicit sub-step over the cells in use; returns 1 if any cell clamped
  function automatic bit grid_sub_step(int xs, int ys, int zs);
    bit     clamped;
    longint c, s, acc, rounded;
    int     xd, xu, yd, yu, zd, zu;
    clamped = 0;
    for (int x = 0; x < xs; x++)
      for (int y = 0; y < ys; y++)
        for (int z = 0; z < zs; z++) begin
          // periodic wrap of the six neighbours
          xd = (x == 0) ? xs - 1 : x - 1;
          xu = (x + 1 >= xs) ? 0 : x + 1;
          yd = (y == 0) ? ys - 1 : y - 1;
          yu = (y + 1 >= ys) ? 0 : y + 1;
          zd = (z == 0) ? zs - 1 : z - 1;
          zu = (z + 1 >= zs) ? 0 : z + 1;
          c = grid_cells[cell_at(x, y, z)];
          s = longint'(grid_cells[cell_at(xd, y, z)]) + grid_cells[cell_at(xu, y, z)]
            + grid_cells[cell_at(x, yd, z)] + grid_cells[cell_at(x, yu, z)]
            + grid_cells[cell_at(x, y, zd)] + grid_cells[cell_at(x, y, zu)] - 6 * c;
          acc = c * 65536 - longint'(decay_reg) * c + longint'(diff_reg) * s;
          if (acc < 0) begin
            grid_next[cell_at(x, y, z)] = '0;
            clamped = 1;
          end else begin
            rounded = (acc + 32768) >>> 16;   // round half up
            if (rounded > longint'(VAL_MAX)) begin
              rounded = VAL_MAX;
              clamped = 1;
            end
            grid_next[cell_at(x, y, z)] = rounded[30:0];
          end
        end
    // double buffer: copy the new grid back only after the whole sweep
    for (int x = 0; x < xs; x++)
      for (int y = 0; y < ys; y++)
        for (int z = 0; z < zs; z++)
          grid_cells[cell_at(x, y, z)] = grid_next[cell_at(x, y, z)];
    return clamped;
  endfunction

  // expected result of one accepted request, updating the model grid
  function automatic result_t grid_outcome(request_t r);
    result_t res;
    int      xs, ys, zs, a;
    longint  v;
    xs = eff_size(x_size_reg);
    ys = eff_size(y_size_reg);
    zs = eff_size(z_size_reg);
    res = '0;
    if (r.op == OP_RUN) begin
      for (int n = 0; n < r.step_count; n++)
        if (grid_sub_step(xs, ys, zs)) res.status = ST_CLAMP;
    end else if (r.x_index >= xs || r.y_index >= ys || r.z_index >= zs) begin
      res.status = ST_RANGE;
    end else begin
      a = cell_at(r.x_index, r.y_index, r.z_index);
      if (r.op != OP_READ) begin
        v = (r.op == OP_WRITE) ? longint'(r.amount)
                               : longint'(grid_cells[a]) + longint'(r.amount);
        if (v < 0) begin
          v = 0;
          res.status = ST_CLAMP;
        end else if (v > longint'(VAL_MAX)) begin
          v = VAL_MAX;
          res.status = ST_CLAMP;
        end
        grid_cells[a] = v[30:0];
      end
      res.cell_value = grid_cells[a];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // send one request; start stays high so back-to-back requests need no gap
  task automatic send_request(request_t r);
    if (allow_idle && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    expected_results.push_back(grid_outcome(r));
  endtask

  task automatic send_cell(logic [1:0] op, int x, int y, int z, int amt);
    request_t r;
    r = '0;
    r.op = op;
    r.x_index = 4'(x);
    r.y_index = 4'(y);
    r.z_index = 4'(z);
    r.amount = amt;
    r.step_count = 8'($urandom);   // ignored by cell commands
    send_request(r);
  endtask

  task automatic send_run(int steps);
    request_t r;
    r = '0;
    r.op = OP_RUN;
    r.x_index = 4'($urandom);
    r.y_index = 4'($urandom);
    r.z_index = 4'($urandom);
    r.amount = $urandom;
    r.step_count = 8'(steps);
    send_request(r);
  endtask

  // register write: setup cycle, then access cycle
  task automatic reg_write(logic [4:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      REG_X_SIZE: x_size_reg = data[4:0];
      REG_Y_SIZE: y_size_reg = data[4:0];
      REG_Z_SIZE: z_size_reg = data[4:0];
      REG_DECAY:  decay_reg  = data[15:0];
      REG_DIFF:   diff_reg   = data[13:0];
      default: ;
    endcase
  endtask

  // reconfigure only once every pending result has come back
  task automatic set_grid(int xs, int ys, int zs, int decay, int diff);
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    reg_write(REG_X_SIZE, xs);
    reg_write(REG_Y_SIZE, ys);
    reg_write(REG_Z_SIZE, zs);
    reg_write(REG_DECAY, decay);
    reg_write(REG_DIFF, diff);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // writes, adds and reads at the value extremes, clamping and range errors
  task automatic test_cell_access();
    set_grid(4, 3, 2, 0, 0);
    send_cell(OP_WRITE, 3, 2, 1, 32'h7FFF_FFFF);
    send_cell(OP_ADD,   3, 2, 1, 1);              // add past the maximum
    send_cell(OP_WRITE, 0, 0, 0, -5);             // negative write clamps to zero
    send_cell(OP_ADD,   0, 0, 0, 32'h8000_0000);  // add below zero
    send_cell(OP_WRITE, 1, 1, 0, 32'h8000_0000);
    send_cell(OP_WRITE, 1, 1, 1, 12345);
    send_cell(OP_ADD,   1, 1, 1, -345);
    send_cell(OP_READ,  3, 2, 1, 0);
    send_cell(OP_WRITE, 4, 0, 0, 7);              // x just outside the grid
    send_cell(OP_READ,  0, 15, 0, 0);
    send_cell(OP_ADD,   0, 0, 15, 9);
  endtask

  // runs: zero steps, plain steps, 2D grid with the largest diffusion, decay-only long run
  task automatic test_runs();
    set_grid(4, 3, 2, 16'h1000, 14'h0800);
    send_run(0);
    send_run(1);
    send_cell(OP_READ, 1, 1, 1, 0);
    send_run(3);
    set_grid(3, 3, 1, 0, 14'h3FFF);               // 2D, largest diffusion
    send_cell(OP_WRITE, 1, 1, 0, 32'h4000_0000);
    send_run(2);
    send_cell(OP_READ, 0, 1, 0, 0);
    set_grid(1, 1, 1, 16'hFFFF, 0);               // decay only, longest run
    send_cell(OP_WRITE, 0, 0, 0, 32'h7FFF_FFFF);
    send_run(255);
    send_cell(OP_READ, 0, 0, 0, 0);
  endtask

  // size registers of zero and above the grid, plus an unused register address
  task automatic test_size_extremes();
    set_grid(0, 31, 0, 16'h0100, 14'h0010);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_cell(OP_WRITE, 0, 15, 0, 1000);
    send_cell(OP_READ, 0, 15, 0, 0);
    send_cell(OP_READ, 1, 0, 0, 0);
    send_run(1);
  endtask

  // random requests with the current sizes; runs kept short on large grids
  task automatic random_requests(int count);
    int xs, ys, zs, step_cap, pick;
    xs = eff_size(x_size_reg);
    ys = eff_size(y_size_reg);
    zs = eff_size(z_size_reg);
    step_cap = 2048 / (xs * ys * zs);
    if (step_cap < 1) step_cap = 1;
    if (step_cap > 255) step_cap = 255;
    for (int n = 0; n < count; n++) begin
      int x, y, z, amt;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      op = (pick < 40) ? OP_WRITE : (pick < 60) ? OP_ADD : (pick < 85) ? OP_READ : OP_RUN;
      // mostly inside the grid, sometimes any index
      if ($urandom_range(0, 99) < 85) begin
        x = $urandom_range(0, xs - 1);
        y = $urandom_range(0, ys - 1);
        z = $urandom_range(0, zs - 1);
      end else begin
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        z = $urandom_range(0, 15);
      end
      case ($urandom_range(0, 3))
        0: amt = $urandom_range(0, 100000);
        1: amt = -$urandom_range(0, 100000);
        2: amt = 32'h7FFF_0000 + $urandom_range(0, 16'hFFFF);
        default: amt = $urandom;
      endcase
      if (op == OP_RUN)
        send_run($urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, step_cap));
      else
        send_cell(op, x, y, z, amt);
    end
  endtask

  task automatic test_random();
    set_grid(2, 3, 1, $urandom_range(0, 16'h0800), $urandom_range(0, 14'h3FFF));
    random_requests(30);
    allow_idle = 0;                                // back-to-back stretch
    set_grid(4, 4, 4, $urandom_range(0, 16'hFFFF), $urandom_range(0, 14'h1FFF));
    random_requests(30);
    allow_idle = 1;
    set_grid(16, 16, 16, 16'h0040, 14'h0200);     // full grid, at most one step per run
    random_requests(25);
    set_grid(1, 5, 2, 16'hFFFF, 14'h3FFF);
    random_requests(30);
  endtask

  // ---------------------------------------------------------------------------
  // result checker: one result per request, in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: cell_value %h status %0d",
               result.cell_value, result.status);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (result.cell_value !== want.cell_value) begin
          $error("cell_value expected %h actual %h", want.cell_value, result.cell_value);
          failures++;
        end
        if (result.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, result.status);
          failures++;
        end
      end
    end
  end

  // watchdog: cycles with neither a request taken nor a result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    failures   = 0;
    idle_cycles = 0;
    allow_idle = 1;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    x_size_reg = 5'd1;
    y_size_reg = 5'd1;
    z_size_reg = 5'd1;
    decay_reg  = '0;
    diff_reg   = '0;
    foreach (grid_cells[i]) grid_cells[i] = '0;
    foreach (grid_next[i]) grid_next[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cell_access();
    test_runs();
    test_size_extremes();
    test_random();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
